/* rtl/jsu_pkg.sv */
`timescale 1ns / 1ps
// Package for the JSON string unescaper: phase and result codes, the result
// bundle passed from the decoder to the result register, and the UTF-8 encoder.
// No dependencies.
package jsu_pkg;

  typedef enum logic [2:0] {
    PH_WAIT = 3'd0,
    PH_STR  = 3'd1,
    PH_ESC  = 3'd2,
    PH_HEX1 = 3'd3,
    PH_BS   = 3'd4,
    PH_U    = 3'd5,
    PH_HEX2 = 3'd6
  } phase_t;

  typedef enum logic [1:0] {
    KIND_BYTE  = 2'd0,
    KIND_CLOSE = 2'd1,
    KIND_ERROR = 2'd2
  } kind_t;

  localparam logic [3:0] ERR_NONE         = 4'd0;
  localparam logic [3:0] ERR_NO_QUOTE     = 4'd1;
  localparam logic [3:0] ERR_CONTROL      = 4'd2;
  localparam logic [3:0] ERR_BAD_ESCAPE   = 4'd3;
  localparam logic [3:0] ERR_BAD_HEX      = 4'd4;
  localparam logic [3:0] ERR_MISSING_LOW  = 4'd5;
  localparam logic [3:0] ERR_BAD_PAIR     = 4'd6;
  localparam logic [3:0] ERR_LONE_LOW     = 4'd7;
  localparam logic [3:0] ERR_UNTERMINATED = 4'd8;

  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_BSL   = 8'h5C;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_U     = 8'h75;

  // Up to four result bytes; last_idx is the index of the final one.
  typedef struct packed {
    logic            valid;
    kind_t           kind;
    logic [3:0]      code;
    logic [1:0]      last_idx;
    logic [3:0][7:0] bytes;
  } res_t;

  function automatic res_t make_err(input logic [3:0] code);
    res_t r;
    r          = '0;
    r.valid    = 1'b1;
    r.kind     = KIND_ERROR;
    r.code     = code;
    return r;
  endfunction

  function automatic res_t make_close();
    res_t r;
    r       = '0;
    r.valid = 1'b1;
    r.kind  = KIND_CLOSE;
    return r;
  endfunction

  function automatic res_t make_byte(input logic [7:0] b);
    res_t r;
    r          = '0;
    r.valid    = 1'b1;
    r.kind     = KIND_BYTE;
    r.bytes[0] = b;
    return r;
  endfunction

  // Code point to UTF-8, byte 0 first on the wire.
  function automatic res_t utf8_encode(input logic [20:0] cp);
    res_t r;
    r       = '0;
    r.valid = 1'b1;
    r.kind  = KIND_BYTE;
    if (cp <= 21'h7F) begin
      r.bytes[0] = cp[7:0];
      r.last_idx = 2'd0;
    end else if (cp <= 21'h7FF) begin
      r.bytes[0] = {3'b110, cp[10:6]};
      r.bytes[1] = {2'b10, cp[5:0]};
      r.last_idx = 2'd1;
    end else if (cp <= 21'hFFFF) begin
      r.bytes[0] = {4'b1110, cp[15:12]};
      r.bytes[1] = {2'b10, cp[11:6]};
      r.bytes[2] = {2'b10, cp[5:0]};
      r.last_idx = 2'd2;
    end else begin
      r.bytes[0] = {5'b11110, cp[20:18]};
      r.bytes[1] = {2'b10, cp[17:12]};
      r.bytes[2] = {2'b10, cp[11:6]};
      r.bytes[3] = {2'b10, cp[5:0]};
      r.last_idx = 2'd3;
    end
    return r;
  endfunction

endpackage

/* rtl/json_string_unescaper.sv */
`timescale 1ns / 1ps
// JSON string unescaper, top level. Instantiates jsu_decode and jsu_burst;
// depends on jsu_pkg.
//
// Input channel (in_valid / in_stall): one raw byte of a JSON string literal
// per transaction, opening quote first; input_end marks the end of the source.
// Output channel (out_valid / out_stall): one result per transaction: a decoded
// content byte, a string-closed marker or an error code. last flags the final
// result caused by an input transaction; a \uXXXX escape or surrogate pair
// yields a run of one to four UTF-8 bytes on the transaction of its last digit.
// An error or the closing quote returns the parser to waiting for a quote.
//
// The byte is held in the input register and is decoded into the result
// register, from which its first result is offered; while the result register
// is busy the byte waits in the input register. Throughput: one input
// transaction per cycle while each gives at most one result and out_stall is
// low; a step that gives several results holds the next byte in the input
// register until the last of them is taken.
// The input register is refilled while a finished result still waits, so a
// stall on the output holds at most one byte behind the result register before
// in_stall rises.
// Reset (rst, synchronous) empties both registers and puts the parser in the
// waiting-for-quote phase.
module json_string_unescaper (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_byte,
  input  logic       input_end,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [1:0] kind,
  output logic [7:0] out_byte,
  output logic [3:0] error_code,
  output logic       last
);

  // input register
  logic          in_full;
  logic [7:0]    byte_r;
  logic          end_r;

  logic          advance;   // decode the held byte this cycle
  logic          burst_done;
  jsu_pkg::res_t res;

  // The held byte moves on once the result register is empty or is handing
  // out its final result in this cycle.
  assign advance  = in_full && (!out_valid || burst_done);
  assign in_stall = in_full && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_valid && !in_stall) begin
      in_full <= 1'b1;
    end else if (advance) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      byte_r <= in_byte;
      end_r  <= input_end;
    end
  end

  jsu_decode u_decode (
    .clk       (clk),
    .rst       (rst),
    .advance   (advance),
    .in_byte   (byte_r),
    .input_end (end_r),
    .res       (res)
  );

  // Steps without a result (quotes opening, escape prefixes, hex digits)
  // leave the result register alone.
  jsu_burst u_burst (
    .clk        (clk),
    .rst        (rst),
    .load       (advance && res.valid),
    .res        (res),
    .out_stall  (out_stall),
    .out_valid  (out_valid),
    .done       (burst_done),
    .kind       (kind),
    .out_byte   (out_byte),
    .error_code (error_code),
    .last       (last)
  );

endmodule

/* rtl/jsu_decode.sv */
`timescale 1ns / 1ps
// Escape decoder: parser state registers and the per-byte step logic.
// Depends on jsu_pkg.
module jsu_decode (
  input  logic           clk,
  input  logic           rst,
  input  logic           advance,
  input  logic [7:0]     in_byte,
  input  logic           input_end,
  output jsu_pkg::res_t  res
);

  jsu_pkg::phase_t phase, phase_next;
  logic [1:0]      hex_count, hex_count_next;
  logic [15:0]     code_unit, code_unit_next;
  logic [9:0]      high_part, high_part_next;

  logic            is_hex;
  logic [3:0]      digit;
  logic [15:0]     unit_shift;
  logic            last_digit;
  logic            is_high;
  logic            is_low;
  logic [20:0]     cp;
  logic            esc_ok;
  logic [7:0]      esc_val;

  // Hex digit decode
  always_comb begin
    is_hex = 1'b1;
    digit  = 4'd0;
    if (in_byte >= 8'h30 && in_byte <= 8'h39) begin
      digit = 4'(in_byte - 8'h30);
    end else if (in_byte >= 8'h61 && in_byte <= 8'h66) begin
      digit = 4'(in_byte - 8'h57);
    end else if (in_byte >= 8'h41 && in_byte <= 8'h46) begin
      digit = 4'(in_byte - 8'h37);
    end else begin
      is_hex = 1'b0;
    end
  end

  assign unit_shift = {code_unit[11:0], digit};
  assign last_digit = (hex_count == 2'd3);
  assign is_high    = (unit_shift[15:10] == 6'b110110);
  assign is_low     = (unit_shift[15:10] == 6'b110111);
  assign cp = (phase == jsu_pkg::PH_HEX2)
            ? ({1'b0, high_part, unit_shift[9:0]} + 21'h10000)
            : {5'd0, unit_shift};

  // Simple escapes
  always_comb begin
    esc_ok  = 1'b1;
    esc_val = 8'h00;
    case (in_byte)
      jsu_pkg::CH_QUOTE: esc_val = jsu_pkg::CH_QUOTE;
      jsu_pkg::CH_BSL:   esc_val = jsu_pkg::CH_BSL;
      jsu_pkg::CH_SLASH: esc_val = jsu_pkg::CH_SLASH;
      8'h62:             esc_val = 8'h08;
      8'h66:             esc_val = 8'h0C;
      8'h6E:             esc_val = 8'h0A;
      8'h72:             esc_val = 8'h0D;
      8'h74:             esc_val = 8'h09;
      default:           esc_ok  = 1'b0;
    endcase
  end

  // Next state
  always_comb begin
    phase_next     = phase;
    hex_count_next = hex_count;
    code_unit_next = code_unit;
    high_part_next = high_part;
    if (input_end) begin
      phase_next = jsu_pkg::PH_WAIT;
      if (phase != jsu_pkg::PH_WAIT) begin
        hex_count_next = 2'd0;
      end
    end else begin
      case (phase)
        jsu_pkg::PH_STR: begin
          if (in_byte == jsu_pkg::CH_QUOTE) begin
            phase_next = jsu_pkg::PH_WAIT;
          end else if (in_byte == jsu_pkg::CH_BSL) begin
            phase_next = jsu_pkg::PH_ESC;
          end else if (in_byte < 8'h20) begin
            phase_next     = jsu_pkg::PH_WAIT;
            hex_count_next = 2'd0;
          end
        end
        jsu_pkg::PH_ESC: begin
          if (in_byte == jsu_pkg::CH_U) begin
            phase_next     = jsu_pkg::PH_HEX1;
            hex_count_next = 2'd0;
            code_unit_next = 16'd0;
          end else if (esc_ok) begin
            phase_next = jsu_pkg::PH_STR;
          end else begin
            phase_next     = jsu_pkg::PH_WAIT;
            hex_count_next = 2'd0;
          end
        end
        jsu_pkg::PH_BS: begin
          if (in_byte == jsu_pkg::CH_BSL) begin
            phase_next = jsu_pkg::PH_U;
          end else begin
            phase_next     = jsu_pkg::PH_WAIT;
            hex_count_next = 2'd0;
          end
        end
        jsu_pkg::PH_U: begin
          if (in_byte == jsu_pkg::CH_U) begin
            phase_next     = jsu_pkg::PH_HEX2;
            hex_count_next = 2'd0;
            code_unit_next = 16'd0;
          end else begin
            phase_next     = jsu_pkg::PH_WAIT;
            hex_count_next = 2'd0;
          end
        end
        jsu_pkg::PH_HEX1, jsu_pkg::PH_HEX2: begin
          if (!is_hex) begin
            phase_next     = jsu_pkg::PH_WAIT;
            hex_count_next = 2'd0;
          end else begin
            code_unit_next = unit_shift;
            hex_count_next = hex_count + 2'd1;
            if (last_digit) begin
              if (phase == jsu_pkg::PH_HEX1 && is_high) begin
                high_part_next = unit_shift[9:0];
                phase_next     = jsu_pkg::PH_BS;
              end else if (phase == jsu_pkg::PH_HEX1 && is_low) begin
                phase_next = jsu_pkg::PH_WAIT;
              end else if (phase == jsu_pkg::PH_HEX2 && !is_low) begin
                phase_next = jsu_pkg::PH_WAIT;
              end else begin
                phase_next = jsu_pkg::PH_STR;
              end
            end
          end
        end
        default: begin
          // waiting for the opening quote (also the unused code)
          phase_next = (in_byte == jsu_pkg::CH_QUOTE) ? jsu_pkg::PH_STR : jsu_pkg::PH_WAIT;
          if (in_byte != jsu_pkg::CH_QUOTE) begin
            hex_count_next = 2'd0;
          end
        end
      endcase
    end
  end

  // Results of this step
  always_comb begin
    res = '0;
    if (input_end) begin
      if (phase != jsu_pkg::PH_WAIT && phase <= jsu_pkg::PH_HEX2) begin
        res = jsu_pkg::make_err(jsu_pkg::ERR_UNTERMINATED);
      end
    end else begin
      case (phase)
        jsu_pkg::PH_STR: begin
          if (in_byte == jsu_pkg::CH_QUOTE) begin
            res = jsu_pkg::make_close();
          end else if (in_byte == jsu_pkg::CH_BSL) begin
            res = '0;
          end else if (in_byte < 8'h20) begin
            res = jsu_pkg::make_err(jsu_pkg::ERR_CONTROL);
          end else begin
            res = jsu_pkg::make_byte(in_byte);
          end
        end
        jsu_pkg::PH_ESC: begin
          if (esc_ok) begin
            res = jsu_pkg::make_byte(esc_val);
          end else if (in_byte != jsu_pkg::CH_U) begin
            res = jsu_pkg::make_err(jsu_pkg::ERR_BAD_ESCAPE);
          end
        end
        jsu_pkg::PH_BS: begin
          if (in_byte != jsu_pkg::CH_BSL) begin
            res = jsu_pkg::make_err(jsu_pkg::ERR_MISSING_LOW);
          end
        end
        jsu_pkg::PH_U: begin
          if (in_byte != jsu_pkg::CH_U) begin
            res = jsu_pkg::make_err(jsu_pkg::ERR_MISSING_LOW);
          end
        end
        jsu_pkg::PH_HEX1, jsu_pkg::PH_HEX2: begin
          if (!is_hex) begin
            res = jsu_pkg::make_err(jsu_pkg::ERR_BAD_HEX);
          end else if (last_digit) begin
            if (phase == jsu_pkg::PH_HEX1 && is_high) begin
              res = '0;
            end else if (phase == jsu_pkg::PH_HEX1 && is_low) begin
              res = jsu_pkg::make_err(jsu_pkg::ERR_LONE_LOW);
            end else if (phase == jsu_pkg::PH_HEX2 && !is_low) begin
              res = jsu_pkg::make_err(jsu_pkg::ERR_BAD_PAIR);
            end else begin
              res = jsu_pkg::utf8_encode(cp);
            end
          end
        end
        default: begin
          if (in_byte != jsu_pkg::CH_QUOTE) begin
            res = jsu_pkg::make_err(jsu_pkg::ERR_NO_QUOTE);
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= jsu_pkg::PH_WAIT;
      hex_count <= 2'd0;
      code_unit <= 16'd0;
      high_part <= 10'd0;
    end else if (advance) begin
      phase     <= phase_next;
      hex_count <= hex_count_next;
      code_unit <= code_unit_next;
      high_part <= high_part_next;
    end
  end

endmodule

/* rtl/jsu_burst.sv */
`timescale 1ns / 1ps
// Result register: holds the results of one step and hands them out one per
// transaction. Depends on jsu_pkg.
module jsu_burst (
  input  logic          clk,
  input  logic          rst,
  input  logic          load,
  input  jsu_pkg::res_t res,
  input  logic          out_stall,
  output logic          out_valid,
  output logic          done,
  output logic [1:0]    kind,
  output logic [7:0]    out_byte,
  output logic [3:0]    error_code,
  output logic          last
);

  logic          busy;
  logic [1:0]    idx;
  jsu_pkg::res_t held;

  assign out_valid  = busy;
  assign last       = (idx == held.last_idx);
  assign done       = busy && !out_stall && last;
  assign kind       = 2'(held.kind);
  assign out_byte   = held.bytes[idx];
  assign error_code = held.code;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      idx  <= 2'd0;
    end else if (load) begin
      busy <= 1'b1;
      idx  <= 2'd0;
    end else if (done) begin
      busy <= 1'b0;
    end else if (busy && !out_stall) begin
      idx <= idx + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      held <= res;
    end
  end

endmodule
